// ===== hdl/lbcm_pkg.sv =====
// Package for the LRU buffer cache manager: request, command and status codes,
// request and result payload types. No dependencies.
`default_nettype none
package lbcm_pkg;
   localparam logic [2:0] REQ_GET_NORMAL   = 3'd0;
   localparam logic [2:0] REQ_GET_NOREAD   = 3'd1;
   localparam logic [2:0] REQ_GET_PREFETCH = 3'd2;
   localparam logic [2:0] REQ_RELEASE      = 3'd3;
   localparam logic [2:0] REQ_MARK_DIRTY   = 3'd4;
   localparam logic [2:0] REQ_FLUSH        = 3'd5;
   localparam logic [2:0] REQ_INVALIDATE   = 3'd6;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ALL_USED  = 2'd1;
   localparam logic [1:0] ST_BAD_REL   = 2'd2;
   localparam logic [1:0] ST_SATURATED = 2'd3;

   localparam logic [31:0] TAG_NONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] block_nr;
      logic [3:0]  buffer_index;
   } req_type_t_type;

   typedef struct packed {
      logic [3:0]  entry_index;
      logic        hit;
      logic [1:0]  command;
      logic [31:0] command_block;
      logic [3:0]  command_entry;
      logic [1:0]  status;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hdl/lbcm_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type is a type parameter.
`default_nettype none
interface lbcm_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/lbcm_tag_cell.sv =====
// One cache entry cell: tag, valid, dirty, reference count, and a slot of the
// free list that shifts toward its left neighbor. Depends on lbcm_pkg.
`default_nettype none
module lbcm_tag_cell #(
   parameter int IW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [IW-1:0] self_index,
   // entry state updates
   input  wire logic          ld_en,
   input  wire logic [31:0]   ld_tag,
   input  wire logic          ld_valid,
   input  wire logic          cnt_inc,
   input  wire logic          cnt_dec,
   input  wire logic          dirty_set,
   input  wire logic          dirty_clr,
   input  wire logic          inval,
   input  wire logic [31:0]   lookup_tag,
   output logic               match,
   output logic [31:0]        tag,
   output logic               dirty,
   output logic               valid,
   output logic [7:0]         count,
   // free list slot
   input  wire logic          fl_shift,
   input  wire logic [IW-1:0] fl_right,
   input  wire logic          fl_load,
   input  wire logic [IW-1:0] fl_load_val,
   output logic [IW-1:0]      fl_val
);
   logic [31:0]   tag_ff;
   logic          valid_ff, dirty_ff;
   logic [7:0]    count_ff;
   logic [IW-1:0] fl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= lbcm_pkg::TAG_NONE;
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         count_ff <= 8'd0;
         fl_ff    <= self_index;
      end else begin
         if (inval) begin
            tag_ff   <= lbcm_pkg::TAG_NONE;
            valid_ff <= 1'b0;
         end else if (ld_en) begin
            tag_ff   <= ld_tag;
            valid_ff <= ld_valid;
         end
         if (ld_en) count_ff <= 8'd1;
         else if (cnt_inc) count_ff <= count_ff + 8'd1;
         else if (cnt_dec) count_ff <= count_ff - 8'd1;
         if (dirty_set) dirty_ff <= 1'b1;
         else if (dirty_clr || ld_en) dirty_ff <= 1'b0;
         if (fl_load) fl_ff <= fl_load_val;
         else if (fl_shift) fl_ff <= fl_right;
      end
   end

   assign match  = valid_ff && (tag_ff == lookup_tag);
   assign tag    = tag_ff;
   assign dirty  = dirty_ff;
   assign valid  = valid_ff;
   assign count  = count_ff;
   assign fl_val = fl_ff;
endmodule
`default_nettype wire

// ===== hdl/lru_buffer_cache_manager.sv =====
// LRU buffer cache manager: tag and policy state for a pool of buffers.
// Channels: req (sink) carries req_type, block_nr, buffer_index; rsp (source)
// carries one or more result transactions per request, the final one with
// last set. Write-back results (command write) precede the final result.
// A request is accepted only when the block is idle. The cycle after
// acceptance does the parallel lookup; the final state then registers the
// final result in the output register once that register is free. A hit on
// an entry that sat in the free list adds a shift state, in which the free
// list closes the gap in a single shift. Sync, invalidate and a miss whose
// victim is valid and dirty add a flush walk, which scans one entry per cycle
// while no write-back waits on a stalled receiver; write-backs go out during
// the scan. Reset is synchronous: all tags become all ones, counts and flags
// clear, the free list holds entries 0..NUM_ENTRIES-1 in order. When the
// receiver stalls, the result is held in the output register and the walk
// waits.
// Depends on lbcm_pkg, lbcm_if and lbcm_tag_cell.
`default_nettype none
module lru_buffer_cache_manager #(
   parameter int NUM_ENTRIES = 16
) (
   input wire logic clock,
   input wire logic reset,
   lbcm_if.sink     req,
   lbcm_if.source   rsp
);
   localparam int IW = $clog2(NUM_ENTRIES);
   localparam int CW = $clog2(NUM_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(NUM_ENTRIES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_FLUSH = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   lbcm_pkg::req_type_t_type rq_ff;
   logic [CW-1:0] fc_ff, fc_in;
   logic [IW:0]   scan_ff, scan_in;   // flush walk position
   logic [IW-1:0] grant_ff, grant_in;
   logic          ghit_ff, ghit_in;
   logic [1:0]    gst_ff, gst_in;
   logic          miss_ff, miss_in;
   lbcm_pkg::rsp_type out_ff, out_in;
   logic          ov_ff, ov_in;

   logic [NUM_ENTRIES-1:0] match, dirty, valid;
   logic [31:0]   tags [NUM_ENTRIES];
   logic [7:0]    cnts [NUM_ENTRIES];
   logic [IW-1:0] fl   [NUM_ENTRIES];

   logic [NUM_ENTRIES-1:0] ld_en, c_inc, c_dec, d_set, d_clr, fl_shift, fl_load;
   logic inval;
   logic [IW-1:0] fl_load_val;

   // hit index and free list position (combinational over the row)
   logic          any_hit;
   logic [IW-1:0] hit_idx;
   logic [IW-1:0] pos_idx;
   logic          pos_found;
   logic [IW-1:0] scan_e;
   logic          out_free;

   always_comb begin
      any_hit = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (match[i] && !any_hit) begin
            any_hit = 1'b1;
            hit_idx = IW'(i);
         end
   end

   always_comb begin
      pos_found = 1'b0;
      pos_idx   = '0;
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (!pos_found && (IW+1)'(i) < (IW+1)'(fc_ff) && fl[i] == grant_ff) begin
            pos_found = 1'b1;
            pos_idx   = IW'(i);
         end
   end

   assign scan_e   = scan_ff[IW-1:0];
   assign out_free = !ov_ff || rsp.ready;

   genvar g;
   generate
      for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
         lbcm_tag_cell #(.IW(IW)) u_cell (
            .clock(clock), .reset(reset), .self_index(IW'(g)),
            .ld_en(ld_en[g]), .ld_tag(rq_ff.block_nr),
            .ld_valid(rq_ff.req_type != lbcm_pkg::REQ_GET_PREFETCH),
            .cnt_inc(c_inc[g]), .cnt_dec(c_dec[g]),
            .dirty_set(d_set[g]), .dirty_clr(d_clr[g]), .inval(inval),
            .lookup_tag(rq_ff.block_nr), .match(match[g]), .tag(tags[g]),
            .dirty(dirty[g]), .valid(valid[g]), .count(cnts[g]),
            .fl_shift(fl_shift[g]),
            .fl_right((g == NUM_ENTRIES-1) ? fl[g] : fl[(g+1) % NUM_ENTRIES]),
            .fl_load(fl_load[g]), .fl_load_val(fl_load_val), .fl_val(fl[g])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff; fc_in = fc_ff; scan_in = scan_ff;
      grant_in = grant_ff; ghit_in = ghit_ff; gst_in = gst_ff; miss_in = miss_ff;
      out_in = out_ff; ov_in = ov_ff && !rsp.ready;
      ld_en = '0; c_inc = '0; c_dec = '0; d_set = '0; d_clr = '0;
      fl_shift = '0; fl_load = '0; fl_load_val = '0; inval = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) state_in = S_LOOK;
         end
         S_LOOK: begin
            gst_in = lbcm_pkg::ST_OK; ghit_in = 1'b0; miss_in = 1'b0;
            grant_in = '0; scan_in = '0;
            state_in = S_FINAL;
            if (rq_ff.req_type <= lbcm_pkg::REQ_GET_PREFETCH) begin
               if (any_hit) begin
                  ghit_in = 1'b1; grant_in = hit_idx;
                  if (cnts[hit_idx] == 8'd255) gst_in = lbcm_pkg::ST_SATURATED;
                  else c_inc[hit_idx] = 1'b1;
                  if (cnts[hit_idx] == 8'd0) state_in = S_SHIFT;
               end else if (fc_ff == '0) begin
                  gst_in = lbcm_pkg::ST_ALL_USED;
               end else begin
                  // take the oldest free entry; victim valid and dirty => flush first
                  miss_in = 1'b1;
                  grant_in = fl[0];
                  scan_in = '0;
                  for (int i = 0; i < NUM_ENTRIES - 1; i++) fl_shift[i] = 1'b1;
                  fc_in = fc_ff - CW'(1);
                  if (valid[fl[0]] && dirty[fl[0]]) state_in = S_FLUSH;
               end
            end else if (rq_ff.req_type == lbcm_pkg::REQ_RELEASE) begin
               grant_in = rq_ff.buffer_index[IW-1:0];
               if (32'(rq_ff.buffer_index) >= 32'(NUM_ENTRIES) ||
                   cnts[rq_ff.buffer_index[IW-1:0]] == 8'd0) begin
                  gst_in = lbcm_pkg::ST_BAD_REL;
               end else begin
                  c_dec[rq_ff.buffer_index[IW-1:0]] = 1'b1;
                  if (cnts[rq_ff.buffer_index[IW-1:0]] == 8'd1 && fc_ff < FULL) begin
                     fl_load[fc_ff[IW-1:0]] = 1'b1;
                     fl_load_val = rq_ff.buffer_index[IW-1:0];
                     fc_in = fc_ff + CW'(1);
                  end
               end
            end else if (rq_ff.req_type == lbcm_pkg::REQ_MARK_DIRTY) begin
               if (32'(rq_ff.buffer_index) < 32'(NUM_ENTRIES))
                  d_set[rq_ff.buffer_index[IW-1:0]] = 1'b1;
            end else if (rq_ff.req_type == lbcm_pkg::REQ_FLUSH ||
                         rq_ff.req_type == lbcm_pkg::REQ_INVALIDATE) begin
               state_in = S_FLUSH;
            end
         end
         S_SHIFT: begin
            // remove the hit entry from the middle of the free list
            for (int i = 0; i < NUM_ENTRIES - 1; i++)
               if (IW'(i) >= pos_idx) fl_shift[i] = 1'b1;
            if (pos_found) fc_in = fc_ff - CW'(1);
            state_in = S_FINAL;
         end
         S_FLUSH: begin
            if (dirty[scan_e]) begin
               if (out_free) begin
                  out_in = '{entry_index: miss_ff ? 4'(grant_ff) : 4'd0, hit: 1'b0,
                             command: lbcm_pkg::CMD_WRITE, command_block: tags[scan_e],
                             command_entry: 4'(scan_e), status: lbcm_pkg::ST_OK,
                             last: 1'b0};
                  ov_in = 1'b1;
                  d_clr[scan_e] = 1'b1;
                  scan_in = scan_ff + (IW+1)'(1);
               end
            end else begin
               scan_in = scan_ff + (IW+1)'(1);
            end
            if (scan_in == (IW+1)'(NUM_ENTRIES)) state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               out_in = '{entry_index: 4'(grant_ff), hit: ghit_ff,
                          command: lbcm_pkg::CMD_NONE, command_block: '0,
                          command_entry: '0, status: gst_ff, last: 1'b1};
               if (rq_ff.req_type == lbcm_pkg::REQ_RELEASE ||
                   rq_ff.req_type == lbcm_pkg::REQ_MARK_DIRTY)
                  out_in.entry_index = rq_ff.buffer_index;
               if (miss_ff) begin
                  ld_en[grant_ff] = 1'b1;
                  if (rq_ff.req_type == lbcm_pkg::REQ_GET_NORMAL) begin
                     out_in.command = lbcm_pkg::CMD_READ;
                     out_in.command_block = rq_ff.block_nr;
                     out_in.command_entry = 4'(grant_ff);
                  end
               end
               if (rq_ff.req_type == lbcm_pkg::REQ_INVALIDATE) inval = 1'b1;
               ov_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_in) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fc_ff    <= FULL;
         ov_ff    <= 1'b0;
         miss_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         ov_ff    <= ov_in;
         miss_ff  <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) rq_ff <= req.payload;
      scan_ff  <= scan_in;
      grant_ff <= grant_in;
      ghit_ff  <= ghit_in;
      gst_ff   <= gst_in;
      out_ff   <= out_in;
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = ov_ff;
   assign rsp.payload = out_ff;

   // free count never exceeds the pool
   a_fc_range: assert property (@(posedge clock) disable iff (reset) fc_ff <= FULL)
      else $error("free count out of range");
   // no request accepted while a result is pending
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !ov_ff)
      else $error("accepted while busy");
   // a final result returns to idle once taken
   a_final: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && out_ff.last) |=> state_ff == S_IDLE)
      else $error("final result did not end the request");
endmodule
`default_nettype wire

// ===== sim/lru_buffer_cache_manager_tb.sv =====
// Testbench for the LRU buffer cache manager: drives get, release, mark-dirty,
// sync and invalidate requests and checks every result transaction against a
// behavioral copy of the cache state. Depends on lbcm_pkg, lbcm_if and the RTL.
`timescale 1ns / 100ps
module lru_buffer_cache_manager_tb;
   localparam int NENT = 16;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbcm_if #(.payload_type(lbcm_pkg::req_type_t_type)) req_ch (clock);
   lbcm_if #(.payload_type(lbcm_pkg::rsp_type)) rsp_ch (clock);

   lru_buffer_cache_manager #(.NUM_ENTRIES(NENT)) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the cache state.
   logic [31:0] tags [NENT];
   logic        vbit [NENT];
   logic        dbit [NENT];
   logic [7:0]  refc [NENT];
   logic [3:0]  lru_list [$];

   lbcm_pkg::req_type_t_type pending_reqs [$];
   lbcm_pkg::rsp_type        expected_rsps [$];
   logic [31:0]    used_blocks [$];
   int  errors = 0;
   int  cycles = 0;
   int  hits_seen = 0;
   int  writes_seen = 0;
   bit  quiet_sender = 1'b0;
   bit  quiet_receiver = 1'b0;
   bit  hold_sender = 1'b0;
   bit  stim_done = 1'b0;

   function automatic lbcm_pkg::rsp_type mk_rsp(logic [3:0] ei, logic h, logic [1:0] cmd,
         logic [31:0] blk, logic [3:0] ce, logic [1:0] st, logic lst);
      lbcm_pkg::rsp_type r;
      r.entry_index = ei;
      r.hit = h;
      r.command = cmd;
      r.command_block = blk;
      r.command_entry = ce;
      r.status = st;
      r.last = lst;
      return r;
   endfunction

   task automatic flush_dirty(logic [3:0] ei);
      for (int i = 0; i < NENT; i++) begin
         if (dbit[i]) begin
            expected_rsps.push_back(mk_rsp(ei, 1'b0, lbcm_pkg::CMD_WRITE, tags[i], i[3:0],
               lbcm_pkg::ST_OK, 1'b0));
            dbit[i] = 1'b0;
         end
      end
   endtask

   task automatic predict_cache(lbcm_pkg::req_type_t_type r);
      int hit_at;
      logic [3:0] v;
      hit_at = -1;
      case (r.req_type)
         lbcm_pkg::REQ_GET_NORMAL, lbcm_pkg::REQ_GET_NOREAD,
         lbcm_pkg::REQ_GET_PREFETCH: begin
            for (int i = 0; i < NENT; i++)
               if (hit_at < 0 && vbit[i] && tags[i] == r.block_nr) hit_at = i;
            if (hit_at >= 0) begin
               if (refc[hit_at] == 8'd0)
                  foreach (lru_list[j])
                     if (lru_list[j] == hit_at[3:0]) begin
                        lru_list.delete(j);
                        break;
                     end
               if (refc[hit_at] == 8'd255) begin
                  expected_rsps.push_back(mk_rsp(hit_at[3:0], 1'b1, lbcm_pkg::CMD_NONE, 0, 0,
                     lbcm_pkg::ST_SATURATED, 1'b1));
               end else begin
                  refc[hit_at]++;
                  expected_rsps.push_back(mk_rsp(hit_at[3:0], 1'b1, lbcm_pkg::CMD_NONE, 0, 0,
                     lbcm_pkg::ST_OK, 1'b1));
               end
            end else if (lru_list.size() == 0) begin
               expected_rsps.push_back(mk_rsp(0, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
                  lbcm_pkg::ST_ALL_USED, 1'b1));
            end else begin
               v = lru_list.pop_front();
               if (vbit[v] && dbit[v]) flush_dirty(v);
               tags[v] = r.block_nr;
               refc[v] = 8'd1;
               dbit[v] = 1'b0;
               vbit[v] = (r.req_type != lbcm_pkg::REQ_GET_PREFETCH);
               if (r.req_type == lbcm_pkg::REQ_GET_NORMAL)
                  expected_rsps.push_back(mk_rsp(v, 1'b0, lbcm_pkg::CMD_READ, r.block_nr, v,
                     lbcm_pkg::ST_OK, 1'b1));
               else
                  expected_rsps.push_back(mk_rsp(v, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
                     lbcm_pkg::ST_OK, 1'b1));
            end
         end
         lbcm_pkg::REQ_RELEASE: begin
            if (refc[r.buffer_index] == 8'd0) begin
               expected_rsps.push_back(mk_rsp(r.buffer_index, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
                  lbcm_pkg::ST_BAD_REL, 1'b1));
            end else begin
               refc[r.buffer_index]--;
               if (refc[r.buffer_index] == 8'd0) lru_list.push_back(r.buffer_index);
               expected_rsps.push_back(mk_rsp(r.buffer_index, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
                  lbcm_pkg::ST_OK, 1'b1));
            end
         end
         lbcm_pkg::REQ_MARK_DIRTY: begin
            dbit[r.buffer_index] = 1'b1;
            expected_rsps.push_back(mk_rsp(r.buffer_index, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
               lbcm_pkg::ST_OK, 1'b1));
         end
         lbcm_pkg::REQ_FLUSH, lbcm_pkg::REQ_INVALIDATE: begin
            flush_dirty(4'd0);
            if (r.req_type == lbcm_pkg::REQ_INVALIDATE)
               for (int i = 0; i < NENT; i++) begin
                  vbit[i] = 1'b0;
                  tags[i] = lbcm_pkg::TAG_NONE;
               end
            expected_rsps.push_back(mk_rsp(0, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
               lbcm_pkg::ST_OK, 1'b1));
         end
         default: expected_rsps.push_back(mk_rsp(0, 1'b0, lbcm_pkg::CMD_NONE, 0, 0,
            lbcm_pkg::ST_OK, 1'b1));
      endcase
   endtask

   task automatic queue_req(logic [2:0] kind, logic [31:0] blk, logic [3:0] idx);
      lbcm_pkg::req_type_t_type r;
      r.req_type = kind;
      r.block_nr = blk;
      r.buffer_index = idx;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [31:0] pick_block();
      if (used_blocks.size() > 0 && $urandom_range(99) < 55)
         return used_blocks[$urandom_range(used_blocks.size() - 1)];
      pick_block = $urandom_range(99) < 70 ? 32'($urandom_range(40)) : $urandom;
      used_blocks.push_back(pick_block);
      if (used_blocks.size() > 24) void'(used_blocks.pop_front());
   endfunction

   // Driver: presents queued requests and predicts each one on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_cache(req_ch.payload);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && !hold_sender &&
                (quiet_sender || $urandom_range(99) >= 9)) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= pending_reqs.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result transaction with the oldest expectation.
   always @(posedge clock) begin
      lbcm_pkg::rsp_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet_receiver || $urandom_range(99) >= 9;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transaction %p", got);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.hit) hits_seen++;
               if (got.command == lbcm_pkg::CMD_WRITE) writes_seen++;
               if (got.entry_index !== want.entry_index) begin
                  $error("entry_index expected %0d got %0d", want.entry_index, got.entry_index);
                  errors++;
               end
               if (got.hit !== want.hit) begin
                  $error("hit expected %0d got %0d", want.hit, got.hit);
                  errors++;
               end
               if (got.command !== want.command) begin
                  $error("command expected %0d got %0d", want.command, got.command);
                  errors++;
               end
               if (got.command_block !== want.command_block) begin
                  $error("command_block expected %h got %h", want.command_block,
                     got.command_block);
                  errors++;
               end
               if (got.command_entry !== want.command_entry) begin
                  $error("command_entry expected %0d got %0d", want.command_entry,
                     got.command_entry);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, got.status);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, got.last);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int kind;
      int pct;
      for (int i = 0; i < NENT; i++) begin
         tags[i] = lbcm_pkg::TAG_NONE;
         vbit[i] = 1'b0;
         dbit[i] = 1'b0;
         refc[i] = 8'd0;
         lru_list.push_back(i[3:0]);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every request kind and the corner cases.
      queue_req(lbcm_pkg::REQ_RELEASE, 32'h0, 4'd15);          // release of an unused entry
      queue_req(lbcm_pkg::REQ_GET_NORMAL, 32'h0, 4'd0);
      queue_req(lbcm_pkg::REQ_GET_NOREAD, 32'hFFFF_FFFE, 4'd0);
      queue_req(lbcm_pkg::REQ_GET_PREFETCH, 32'h1234_5678, 4'd0);
      // The prefetched entry is invalid, so this is a miss.
      queue_req(lbcm_pkg::REQ_GET_NORMAL, 32'h1234_5678, 4'd0);
      queue_req(lbcm_pkg::REQ_GET_NORMAL, 32'h0, 4'd0);         // hit
      queue_req(lbcm_pkg::REQ_MARK_DIRTY, 32'h0, 4'd0);
      queue_req(lbcm_pkg::REQ_MARK_DIRTY, 32'h0, 4'd15);        // entry not in use
      queue_req(lbcm_pkg::REQ_FLUSH, 32'h0, 4'd0);
      queue_req(lbcm_pkg::REQ_RELEASE, 32'h0, 4'd0);
      queue_req(lbcm_pkg::REQ_RELEASE, 32'h0, 4'd0);
      queue_req(lbcm_pkg::REQ_MARK_DIRTY, 32'h0, 4'd0);
      queue_req(lbcm_pkg::REQ_INVALIDATE, 32'h0, 4'd0);
      queue_req(3'd7, 32'hFFFF_FFFF, 4'd15);
      // Use up every free entry, then further misses find nothing free.
      for (int i = 0; i < 17; i++) queue_req(lbcm_pkg::REQ_GET_NOREAD, 32'h100 + i, 4'(i));
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      // A dirty valid victim forces a full write-back.
      queue_req(lbcm_pkg::REQ_MARK_DIRTY, 32'h0, 4'd4);
      queue_req(lbcm_pkg::REQ_MARK_DIRTY, 32'h0, 4'd5);
      queue_req(lbcm_pkg::REQ_MARK_DIRTY, 32'h0, 4'd1);
      queue_req(lbcm_pkg::REQ_RELEASE, 32'h0, 4'd4);
      queue_req(lbcm_pkg::REQ_GET_NORMAL, 32'hDEAD_BEEF, 4'd0);

      // Random part, the first stretch without idling on either side.
      for (int n = 0; n < 234; n++) begin
         quiet_sender = (n < 60);
         quiet_receiver = (n < 60);
         pct = $urandom_range(99);
         if (pct < 40) kind = $urandom_range(2);
         else if (pct < 72) kind = lbcm_pkg::REQ_RELEASE;
         else if (pct < 88) kind = lbcm_pkg::REQ_MARK_DIRTY;
         else if (pct < 94) kind = lbcm_pkg::REQ_FLUSH;
         else if (pct < 98) kind = lbcm_pkg::REQ_INVALIDATE;
         else kind = 7;
         queue_req(3'(kind), pick_block(), 4'($urandom_range(15)));
         if (n == 150) begin
            // Sender holds off until every outstanding result has arrived.
            wait (pending_reqs.size() == 0);
            hold_sender = 1'b1;
            wait (expected_rsps.size() == 0 && !req_ch.valid);
            repeat (5) @(posedge clock);
            hold_sender = 1'b0;
         end
         while (pending_reqs.size() > 4) @(posedge clock);
      end
      stim_done = 1'b1;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_ch.valid && expected_rsps.size() == 0);
      repeat (40) @(posedge clock);

      $display("Ran directed and random requests: %0d hits, %0d write-backs observed.",
         hits_seen, writes_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
